// ----- src/bbpe_pkg.sv -----
// Shared constants and types for the bicubic Bezier patch evaluator.
package bbpe_pkg;

  localparam int unsigned NumPts        = 16;
  localparam int unsigned IdxWidth      = 4;
  localparam int unsigned ParamWidth    = 16;
  localparam int unsigned NumStages     = 9;
  localparam int unsigned CoordWidthDef = 24;
  localparam int unsigned FracBitsDef   = 15;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_e;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctl_t;

  typedef struct packed {
    logic                we;
    logic [IdxWidth-1:0] idx;
  } ld_ctl_t;

endpackage

// ----- src/bicubic_bezier_patch_eval_top.sv -----
// Top level of the bicubic Bezier patch evaluator: handshake, valid pipeline, load path.
//
// Evaluates a bicubic Bezier patch over 16 stored control points (Q15.8, cleared
// at reset). A load transfer writes one point and gives no result; an evaluate
// transfer gives one result: the Bernstein-weighted sum at (u, v), rounded to
// nearest and saturated. The block takes one transfer every cycle while no stage
// is held by back-pressure; each result passes through the nine-stage multiplier
// pipeline (weights, pair weights, point products, adder tree, rounding).
// Each stage holds its item under back-pressure. A load updates the store in
// step with evaluates, so every evaluate sees exactly the loads before it.
module bicubic_bezier_patch_eval_top #(
  parameter int unsigned COORD_WIDTH     = bbpe_pkg::CoordWidthDef,
  parameter int unsigned PARAM_FRAC_BITS = bbpe_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [bbpe_pkg::IdxWidth-1:0]       point_index_i,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  input  logic [bbpe_pkg::ParamWidth-1:0]     param_u_i,
  input  logic [bbpe_pkg::ParamWidth-1:0]     param_v_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_WIDTH-1:0]       pos_x_o,
  output logic signed [COORD_WIDTH-1:0]       pos_y_o,
  output logic signed [COORD_WIDTH-1:0]       pos_z_o
);

  localparam int unsigned NS = bbpe_pkg::NumStages;
  localparam int unsigned LdStages = 5;

  logic [NS-1:0]               vld_q, vld_d;
  logic [NS:0]                 rdy;
  bbpe_pkg::pipe_ctl_t         ctl;
  bbpe_pkg::ld_ctl_t           ld;
  bbpe_pkg::mode_e             mode_q [LdStages];
  logic [bbpe_pkg::IdxWidth-1:0] idx_q [LdStages];
  logic [2:0][COORD_WIDTH-1:0] pt_q  [LdStages];
  logic [3:0][PARAM_FRAC_BITS:0] wu, wv;
  logic [2:0][COORD_WIDTH-1:0] pos;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ctl.en = rdy[NS-1:0];
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        vld_d[k] = in_valid_i;
      end else if (k == LdStages) begin
        // loads end here
        vld_d[k] = vld_q[k-1] && (mode_q[k-1] == bbpe_pkg::MODE_EVAL);
      end else begin
        vld_d[k] = vld_q[k-1];
      end
    end
    ld.we  = rdy[LdStages] && vld_q[LdStages-1] && (mode_q[LdStages-1] == bbpe_pkg::MODE_LOAD);
    ld.idx = idx_q[LdStages-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mode_q[0] <= bbpe_pkg::mode_e'(mode_i);
      idx_q[0]  <= point_index_i;
      pt_q[0]   <= {point_z_i, point_y_i, point_x_i};
    end
    for (int k = 1; k < LdStages; k++) begin
      if (rdy[k]) begin
        mode_q[k] <= mode_q[k-1];
        idx_q[k]  <= idx_q[k-1];
        pt_q[k]   <= pt_q[k-1];
      end
    end
  end

  bbpe_bern #(
    .FRAC_BITS(PARAM_FRAC_BITS)
  ) u_bern_u (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .param_i(param_u_i),
    .w_o    (wu)
  );

  bbpe_bern #(
    .FRAC_BITS(PARAM_FRAC_BITS)
  ) u_bern_v (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .param_i(param_v_i),
    .w_o    (wv)
  );

  bbpe_mac #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (PARAM_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .ld_i   (ld),
    .ld_pt_i(pt_q[LdStages-1]),
    .wu_i   (wu),
    .wv_i   (wv),
    .pos_o  (pos)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign pos_x_o     = pos[0];
  assign pos_y_o     = pos[1];
  assign pos_z_o     = pos[2];

  a_empty_head_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_ready_o)
    else $error("input stalled with empty head stage");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transfer lost at head stage");

  a_tail_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-2] && !vld_q[NS-1]) |=> vld_q[NS-1])
    else $error("result not moved into empty output stage");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld.we |=> !vld_q[LdStages] || $past(!vld_q[LdStages] || !rdy[LdStages+1]))
    else $error("load produced a result");

endmodule

// ----- src/bbpe_bern.sv -----
// Cubic Bernstein weight pipeline for one patch parameter (stages 0 to 3).
module bbpe_bern #(
  parameter int unsigned FRAC_BITS = bbpe_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  bbpe_pkg::pipe_ctl_t                 ctl_i,
  input  logic [bbpe_pkg::ParamWidth-1:0]     param_i,
  output logic [3:0][FRAC_BITS:0]             w_o
);

  localparam int unsigned PW   = FRAC_BITS + 1;
  localparam int unsigned CMPW = (PW > bbpe_pkg::ParamWidth) ? PW : bbpe_pkg::ParamWidth;
  localparam int unsigned SW   = 3 * PW + 2;
  localparam logic [PW-1:0] One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] Half = SW'(1) << (2 * FRAC_BITS - 1);

  logic [CMPW-1:0] p_ext;
  logic [PW-1:0]   t0_d, c0_d, t0_q, c0_q;
  logic [PW-1:0]   t1_q, c1_q;
  logic [2*PW-1:0] t2_q, c2_q;
  logic [3*PW-1:0] b_q [4];
  logic [SW-1:0]   s_d [4];
  logic [3:0][PW-1:0] w_d, w_q;

  // stage 0: clamp to one
  always_comb begin
    p_ext = CMPW'(param_i);
    t0_d  = (p_ext > CMPW'(One)) ? One : PW'(p_ext);
    c0_d  = One - t0_d;
  end

  // stage 3: scale middle terms by three, round to FRAC_BITS
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i == 1 || i == 2) begin
        s_d[i] = SW'(b_q[i]) + {SW'(b_q[i]) << 1} + Half;
      end else begin
        s_d[i] = SW'(b_q[i]) + Half;
      end
      w_d[i] = s_d[i][2*FRAC_BITS +: PW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      t0_q <= t0_d;
      c0_q <= c0_d;
    end
    if (ctl_i.en[1]) begin
      t1_q <= t0_q;
      c1_q <= c0_q;
      t2_q <= (2 * PW)'(t0_q) * (2 * PW)'(t0_q);
      c2_q <= (2 * PW)'(c0_q) * (2 * PW)'(c0_q);
    end
    if (ctl_i.en[2]) begin
      b_q[0] <= (3 * PW)'(c2_q) * (3 * PW)'(c1_q);
      b_q[1] <= (3 * PW)'(c2_q) * (3 * PW)'(t1_q);
      b_q[2] <= (3 * PW)'(t2_q) * (3 * PW)'(c1_q);
      b_q[3] <= (3 * PW)'(t2_q) * (3 * PW)'(t1_q);
    end
    if (ctl_i.en[3]) begin
      w_q <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

// ----- src/bbpe_mac.sv -----
// Control point store, pair weights, weighted sum and output rounding (stages 4 to 8).
module bbpe_mac #(
  parameter int unsigned COORD_WIDTH = bbpe_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = bbpe_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bbpe_pkg::pipe_ctl_t             ctl_i,
  input  bbpe_pkg::ld_ctl_t               ld_i,
  input  logic [2:0][COORD_WIDTH-1:0]     ld_pt_i,
  input  logic [3:0][FRAC_BITS:0]         wu_i,
  input  logic [3:0][FRAC_BITS:0]         wv_i,
  output logic [2:0][COORD_WIDTH-1:0]     pos_o
);

  localparam int unsigned PW    = FRAC_BITS + 1;
  localparam int unsigned PRODW = COORD_WIDTH + PW + 1;
  localparam int unsigned GRPW  = PRODW + 2;
  localparam int unsigned ACCW  = PRODW + 4;
  localparam logic [2*PW:0] HalfP = (2 * PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACCW:0] HalfA = (ACCW + 1)'(1) << (FRAC_BITS - 1);

  logic signed [COORD_WIDTH-1:0] pts_q [bbpe_pkg::NumPts][3];
  logic [2*PW:0]                 ps_d  [bbpe_pkg::NumPts];
  logic [PW-1:0]                 pw_q  [bbpe_pkg::NumPts];
  logic signed [PRODW-1:0]       prod_q [3][bbpe_pkg::NumPts];
  logic signed [GRPW-1:0]        grp_d [3][4];
  logic signed [GRPW-1:0]        grp_q [3][4];
  logic signed [ACCW-1:0]        acc_d [3];
  logic signed [ACCW-1:0]        acc_q [3];
  logic signed [ACCW:0]          rnd   [3];
  logic [2:0][COORD_WIDTH-1:0]   pos_d, pos_q;

  // store: written by a load leaving stage 4, read by an evaluate leaving stage 4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < bbpe_pkg::NumPts; n++) begin
        for (int k = 0; k < 3; k++) begin
          pts_q[n][k] <= '0;
        end
      end
    end else if (ld_i.we) begin
      for (int k = 0; k < 3; k++) begin
        pts_q[ld_i.idx][k] <= ld_pt_i[k];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < bbpe_pkg::NumPts; n++) begin
      ps_d[n] = (2 * PW + 1)'(wu_i[n / 4]) * (2 * PW + 1)'(wv_i[n % 4]) + HalfP;
    end
    for (int k = 0; k < 3; k++) begin
      for (int g = 0; g < 4; g++) begin
        grp_d[k][g] = '0;
        for (int m = 0; m < 4; m++) begin
          grp_d[k][g] = grp_d[k][g] + GRPW'(prod_q[k][4 * g + m]);
        end
      end
      acc_d[k] = '0;
      for (int g = 0; g < 4; g++) begin
        acc_d[k] = acc_d[k] + ACCW'(grp_q[k][g]);
      end
      rnd[k] = ((ACCW + 1)'(acc_q[k]) + HalfA) >>> FRAC_BITS;
      if (rnd[k][ACCW:COORD_WIDTH-1] == {(ACCW - COORD_WIDTH + 2){rnd[k][ACCW]}}) begin
        pos_d[k] = rnd[k][COORD_WIDTH-1:0];
      end else begin
        pos_d[k] = {rnd[k][ACCW], {(COORD_WIDTH - 1){~rnd[k][ACCW]}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      for (int n = 0; n < bbpe_pkg::NumPts; n++) begin
        pw_q[n] <= ps_d[n][FRAC_BITS +: PW];
      end
    end
    if (ctl_i.en[5]) begin
      for (int k = 0; k < 3; k++) begin
        for (int n = 0; n < bbpe_pkg::NumPts; n++) begin
          prod_q[k][n] <= PRODW'(pts_q[n][k]) * PRODW'($signed({1'b0, pw_q[n]}));
        end
      end
    end
    if (ctl_i.en[6]) begin
      grp_q <= grp_d;
    end
    if (ctl_i.en[7]) begin
      acc_q <= acc_d;
    end
    if (ctl_i.en[8]) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ----- dv/bicubic_bezier_patch_eval_top_test.sv -----
// Self-checking testbench for the Bezier patch evaluator: load/evaluate traffic and predictor.
module bicubic_bezier_patch_eval_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = bbpe_pkg::CoordWidthDef;
  localparam int FB         = bbpe_pkg::FracBitsDef;
  localparam int IdxWidth   = bbpe_pkg::IdxWidth;
  localparam int ParamWidth = bbpe_pkg::ParamWidth;
  localparam int NumPts     = bbpe_pkg::NumPts;
  localparam int NumStages  = bbpe_pkg::NumStages;
  localparam int ONE      = 1 << FB;
  localparam int N_RANDOM = 1550;
  localparam int HOLD_AT  = 1150;
  localparam int HOLD_LEN = 80;
  localparam int WD_LIMIT = 4000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [3:0][FB:0] wts_t;

  localparam coord_t PT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t PT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) << (CW-1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (CW-1));

  typedef struct {
    bbpe_pkg::mode_e       mode;
    logic [IdxWidth-1:0]   idx;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [ParamWidth-1:0] u;
    logic [ParamWidth-1:0] v;
    bit                    drain_first;
  } patch_cmd_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } surf_pt_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  out_ready_i   = 1'b0;
  logic                  mode_i        = 1'b0;
  logic [IdxWidth-1:0]   point_index_i = '0;
  coord_t                point_x_i     = '0;
  coord_t                point_y_i     = '0;
  coord_t                point_z_i     = '0;
  logic [ParamWidth-1:0] param_u_i     = '0;
  logic [ParamWidth-1:0] param_v_i     = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  coord_t                pos_x_o;
  coord_t                pos_y_o;
  coord_t                pos_z_o;

  patch_cmd_t patch_cmd_q[$];
  surf_pt_t   surf_pt_q[$];
  surf_pt_t   ctrl_pts[NumPts];
  patch_cmd_t offer;
  int         n_queued     = 0;
  int         n_offered    = 0;
  int         n_in_taken   = 0;
  int         n_out        = 0;
  int         n_fail       = 0;
  int         stall_cycles = 0;
  int         hold_left    = 0;
  bit         hold_done    = 1'b0;

  bicubic_bezier_patch_eval_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .point_index_i(point_index_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .param_u_i    (param_u_i),
    .param_v_i    (param_v_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic wts_t bernstein_wts(logic [ParamWidth-1:0] raw);
    longint t;
    longint c;
    longint b[4];
    wts_t   w;
    t = (raw > ONE) ? longint'(ONE) : longint'(raw);
    c = ONE - t;
    b[0] = c * c * c;
    b[1] = 3 * t * c * c;
    b[2] = 3 * t * t * c;
    b[3] = t * t * t;
    for (int i = 0; i < 4; i++) begin
      w[i] = (FB+1)'((b[i] + (longint'(1) << (2*FB-1))) >> (2*FB));
    end
    return w;
  endfunction

  function automatic coord_t round_coord(longint acc);
    longint r;
    r = (acc + (longint'(1) << (FB-1))) >>> FB;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[CW-1:0];
  endfunction

  function automatic surf_pt_t eval_patch(logic [ParamWidth-1:0] u, logic [ParamWidth-1:0] v);
    wts_t     wu;
    wts_t     wv;
    longint   pw;
    longint   ax;
    longint   ay;
    longint   az;
    surf_pt_t p;
    wu = bernstein_wts(u);
    wv = bernstein_wts(v);
    ax = 0;
    ay = 0;
    az = 0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pw = (longint'(wu[i]) * longint'(wv[j]) + (longint'(1) << (FB-1))) >> FB;
        ax += longint'(ctrl_pts[i*4+j].x) * pw;
        ay += longint'(ctrl_pts[i*4+j].y) * pw;
        az += longint'(ctrl_pts[i*4+j].z) * pw;
      end
    end
    p.x = round_coord(ax);
    p.y = round_coord(ay);
    p.z = round_coord(az);
    return p;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(15))
      0:       return PT_MAX;
      1:       return PT_MIN;
      2:       return coord_t'(int'($urandom_range(4095)) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [ParamWidth-1:0] rand_param();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ParamWidth'(ONE);
      2, 3:    return ParamWidth'($urandom_range(65535));
      default: return ParamWidth'($urandom_range(ONE));
    endcase
  endfunction

  // ignored fields carry random values
  function automatic patch_cmd_t load_cmd(int idx, coord_t x, coord_t y, coord_t z);
    patch_cmd_t c;
    c.mode        = bbpe_pkg::MODE_LOAD;
    c.idx         = IdxWidth'(idx);
    c.x           = x;
    c.y           = y;
    c.z           = z;
    c.u           = ParamWidth'($urandom);
    c.v           = ParamWidth'($urandom);
    c.drain_first = 1'b0;
    return c;
  endfunction

  function automatic patch_cmd_t eval_cmd(int u, int v);
    patch_cmd_t c;
    c.mode        = bbpe_pkg::MODE_EVAL;
    c.idx         = IdxWidth'($urandom);
    c.x           = coord_t'($urandom);
    c.y           = coord_t'($urandom);
    c.z           = coord_t'($urandom);
    c.u           = ParamWidth'(u);
    c.v           = ParamWidth'(v);
    c.drain_first = 1'b0;
    return c;
  endfunction

  task automatic queue_cmd(patch_cmd_t c);
    if (n_queued == 700 || n_queued == 1300) c.drain_first = 1'b1;
    patch_cmd_q.insert(patch_cmd_q.size(), c);
    n_queued++;
  endtask

  function automatic int idle_pct(bit rx);
    if (n_in_taken < 500) return rx ? 51 : 11;
    if (n_in_taken < 1000) return rx ? 11 : 51;
    return 0;
  endfunction

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR: %s", msg);
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && n_in_taken != n_offered)) begin
      if (patch_cmd_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0) &&
          !(patch_cmd_q[0].drain_first && surf_pt_q.size() != 0)) begin
        offer = patch_cmd_q.pop_front();
        n_offered++;
        in_valid_i    <= 1'b1;
        mode_i        <= offer.mode;
        point_index_i <= offer.idx;
        point_x_i     <= offer.x;
        point_y_i     <= offer.y;
        point_z_i     <= offer.z;
        param_u_i     <= offer.u;
        param_v_i     <= offer.v;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_in_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk_i) begin
    bit       in_fire;
    bit       out_fire;
    surf_pt_t want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (in_fire) begin
      if (offer.mode == bbpe_pkg::MODE_LOAD) begin
        ctrl_pts[offer.idx] = '{offer.x, offer.y, offer.z};
      end else begin
        surf_pt_q.insert(surf_pt_q.size(), eval_patch(offer.u, offer.v));
      end
      n_in_taken++;
    end
    if (out_fire) begin
      if (surf_pt_q.size() == 0) begin
        note_fail($sformatf("unexpected result (%0d,%0d,%0d)", pos_x_o, pos_y_o, pos_z_o));
      end else begin
        want = surf_pt_q.pop_front();
        if (pos_x_o !== want.x || pos_y_o !== want.y || pos_z_o !== want.z) begin
          note_fail($sformatf("result %0d: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                              n_out, want.x, want.y, want.z, pos_x_o, pos_y_o, pos_z_o));
        end
        n_out++;
      end
    end
    if (!rst_ni || in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sel;
    int kind;
    foreach (ctrl_pts[k]) ctrl_pts[k] = '{'0, '0, '0};

    queue_cmd(eval_cmd(0, 0));
    queue_cmd(eval_cmd(16'hFFFF, 16'hFFFF));
    queue_cmd(load_cmd(0, PT_MAX, PT_MIN, coord_t'(0)));
    queue_cmd(load_cmd(15, PT_MIN, PT_MAX, coord_t'(-1)));
    queue_cmd(load_cmd(3, coord_t'(1), coord_t'(-1), coord_t'(24'h7FFF00)));
    queue_cmd(load_cmd(12, coord_t'(-256), coord_t'(256), PT_MIN));
    queue_cmd(load_cmd(6, coord_t'(24'h555555), coord_t'(24'hAAAAAA), coord_t'(24'h555555)));
    queue_cmd(load_cmd(9, coord_t'(24'hAAAAAA), coord_t'(24'h555555), coord_t'(24'hAAAAAA)));
    queue_cmd(eval_cmd(0, 0));
    queue_cmd(eval_cmd(ONE, ONE));
    queue_cmd(eval_cmd(0, ONE));
    queue_cmd(eval_cmd(ONE, 0));
    queue_cmd(eval_cmd(ONE / 2, ONE / 2));
    queue_cmd(eval_cmd(ONE + 1, 16'hFFFF));
    queue_cmd(eval_cmd(1, ONE - 1));
    queue_cmd(eval_cmd(16'hAAAA, 16'h5555));
    queue_cmd(eval_cmd(16'h5555, 16'h2AAA));
    queue_cmd(load_cmd(0, coord_t'(256), coord_t'(-128), coord_t'(1)));
    queue_cmd(eval_cmd(0, 0));

    // full patch rewrites drive the weight sum past one at the extremes
    while (n_queued < N_RANDOM + 19) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        kind = $urandom_range(3);
        for (int k = 0; k < NumPts; k++) begin
          case (kind)
            0:       queue_cmd(load_cmd(k, PT_MAX, PT_MAX, PT_MAX));
            1:       queue_cmd(load_cmd(k, PT_MIN, PT_MIN, PT_MIN));
            2:       queue_cmd(load_cmd(k, PT_MAX, PT_MIN, rand_coord()));
            default: queue_cmd(load_cmd(k, rand_coord(), rand_coord(), rand_coord()));
          endcase
        end
        repeat (4) queue_cmd(eval_cmd(rand_param(), rand_param()));
      end else if (sel < 40) begin
        queue_cmd(load_cmd($urandom_range(NumPts - 1), rand_coord(), rand_coord(), rand_coord()));
      end else begin
        queue_cmd(eval_cmd(rand_param(), rand_param()));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (patch_cmd_q.size() != 0 || n_in_taken != n_offered || surf_pt_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (NumStages + 8) @(posedge clk_i);
    if (surf_pt_q.size() != 0) note_fail("results still outstanding at end of run");

    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
